>>> sv/swms_pkg.sv
package swms_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned SPREAD_W = 32;
  localparam int unsigned WSZ_W    = 7;

  // configuration port
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam logic        REG_WINDOW_SIZE = 1'b0;  // word index of window_size
  localparam logic [WSZ_W-1:0] WSZ_RESET = 7'd1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SPREAD,
    ST_DONE
  } swms_state_t;

  // control for every cell of the chain
  typedef struct packed {
    logic shift;   // take the neighbour on the newer side (new sample at cell 0)
    logic rotate;  // take the neighbour on the older side (wrap at the end)
  } swms_cell_ctrl_t;

  // control for the min/max accumulator
  typedef struct packed {
    logic init;    // load both bounds from the tap
    logic en;      // fold the tap into the bounds
  } swms_mm_ctrl_t;

endpackage

>>> sv/swms_if.sv
interface swms_in_if
  import swms_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface swms_out_if
  import swms_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SPREAD_W-1:0] max_spread;

  modport source (output valid, output max_spread, input ready);
  modport sink   (input valid, input max_spread, output ready);
endinterface

>>> sv/swms_cell.sv
module swms_cell
  import swms_pkg::*;
(
  input  logic                       clk,
  input  swms_cell_ctrl_t            ctrl,
  input  logic signed [SAMPLE_W-1:0] newer_in,
  input  logic signed [SAMPLE_W-1:0] older_in,
  output logic signed [SAMPLE_W-1:0] q
);

  logic signed [SAMPLE_W-1:0] data_r;

  // one sample of the chain; shift moves data towards older cells,
  // rotate moves it back towards cell 0
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data_r <= newer_in;
    end else if (ctrl.rotate) begin
      data_r <= older_in;
    end
  end

  assign q = data_r;

endmodule

>>> sv/swms_minmax.sv
module swms_minmax
  import swms_pkg::*;
(
  input  logic                       clk,
  input  swms_mm_ctrl_t              ctrl,
  input  logic signed [SAMPLE_W-1:0] tap,
  output logic signed [SAMPLE_W-1:0] lo,
  output logic signed [SAMPLE_W-1:0] hi
);

  logic signed [SAMPLE_W-1:0] lo_r, hi_r;

  // running signed bounds of the window being scanned
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      lo_r <= tap;
      hi_r <= tap;
    end else if (ctrl.en) begin
      if (tap < lo_r) begin
        lo_r <= tap;
      end
      if (tap > hi_r) begin
        hi_r <= tap;
      end
    end
  end

  assign lo = lo_r;
  assign hi = hi_r;

endmodule

>>> sv/sliding_window_max_spread.sv
// Channel   Direction  Payload                         Handshake
// in_if     in         sample (s32), last (1)          valid/ready
// out_if    out        max_spread (u32)                valid/ready
// cfg_*     in/out     window_size at byte address 0   APB, pready always high
//
// An item that closes no window is taken in IDLE alone; one that closes a window
// then stalls the input through SCAN and SPREAD: a shift into the cell chain,
// rotations of the whole chain past the min/max tap at cell 0, and a fold of the
// spread into the running best. An item marked last then passes DONE, which loads
// the result register and stalls the input there while an earlier result is unread.
// Reset clears count, best and result valid, sets window_size to 1; cells keep data.
module sliding_window_max_spread
  import swms_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  swms_in_if.sink            in_if,
  swms_out_if.source         out_if,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  localparam int unsigned CNT_W  = $clog2(WINDOW_MAX + 1) > WSZ_W ?
                                   $clog2(WINDOW_MAX + 1) : WSZ_W;
  localparam int unsigned IDX_W  = $clog2(WINDOW_MAX);
  localparam logic [CNT_W-1:0] WMAX_C   = CNT_W'(WINDOW_MAX);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_MAX - 1);

  swms_state_t state_r, state_nxt;

  logic [WSZ_W-1:0]    wsz_r;
  logic [CNT_W-1:0]    seen_r, seen_nxt;
  logic [IDX_W-1:0]    scan_r;
  logic                last_r;
  logic [SPREAD_W-1:0] best_r, spread;
  logic                out_valid_r;
  logic [SPREAD_W-1:0] out_data_r;

  logic [CNT_W-1:0]    wsz_ext, k_eff;
  logic                in_acc, cfg_wr, out_free;

  swms_cell_ctrl_t            cell_ctrl;
  swms_mm_ctrl_t              mm_ctrl;
  logic                       best_upd, seq_clear, out_load;
  logic signed [SAMPLE_W-1:0] cell_q [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] mm_lo, mm_hi;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[2] == REG_WINDOW_SIZE);
  assign cfg_prdata = (cfg_paddr[2] == REG_WINDOW_SIZE) ?
                      PDATA_W'(wsz_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsz_r <= WSZ_RESET;
    end else if (cfg_wr) begin
      wsz_r <= cfg_pwdata[WSZ_W-1:0];
    end
  end

  // effective window: zero means one, large values clamp to the chain length
  assign wsz_ext = CNT_W'(wsz_r);
  always_comb begin
    priority if (wsz_ext == '0) begin
      k_eff = CNT_W'(1);
    end else if (wsz_ext > WMAX_C) begin
      k_eff = WMAX_C;
    end else begin
      k_eff = wsz_ext;
    end
  end

  assign in_acc   = in_if.valid && in_if.ready;
  assign seen_nxt = (seen_r < WMAX_C) ? seen_r + CNT_W'(1) : seen_r;
  assign out_free = !out_valid_r || out_if.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (seen_nxt >= k_eff) begin
            state_nxt = ST_SCAN;
          end else if (in_if.last) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_r == LAST_IDX) begin
          state_nxt = ST_SPREAD;
        end
      end
      ST_SPREAD: begin
        state_nxt = last_r ? ST_DONE : ST_IDLE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_if.ready      = 1'b0;
    cell_ctrl.shift  = 1'b0;
    cell_ctrl.rotate = 1'b0;
    mm_ctrl.init     = 1'b0;
    mm_ctrl.en       = 1'b0;
    best_upd         = 1'b0;
    seq_clear        = 1'b0;
    out_load         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_if.ready     = 1'b1;
        cell_ctrl.shift = in_if.valid;
      end
      ST_SCAN: begin
        cell_ctrl.rotate = 1'b1;
        mm_ctrl.init     = (scan_r == '0);
        mm_ctrl.en       = (CNT_W'(scan_r) < k_eff);
      end
      ST_SPREAD: begin
        best_upd = 1'b1;
      end
      ST_DONE: begin
        seq_clear = out_free;
        out_load  = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequence bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (seq_clear) begin
      seen_r <= '0;
    end else if (in_acc) begin
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      last_r <= in_if.last;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r != ST_SCAN) begin
      scan_r <= '0;
    end else begin
      scan_r <= scan_r + IDX_W'(1);
    end
  end

  // chain of sample cells; cell 0 holds the newest sample and feeds the tap
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic signed [SAMPLE_W-1:0] newer, older;
    if (i == 0) begin : g_head
      assign newer = in_if.sample;
    end else begin : g_body
      assign newer = cell_q[i-1];
    end
    if (i == WINDOW_MAX - 1) begin : g_tail
      assign older = cell_q[0];
    end else begin : g_mid
      assign older = cell_q[i+1];
    end
    swms_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .newer_in (newer),
      .older_in (older),
      .q        (cell_q[i])
    );
  end

  swms_minmax u_mm (
    .clk  (clk),
    .ctrl (mm_ctrl),
    .tap  (cell_q[0]),
    .lo   (mm_lo),
    .hi   (mm_hi)
  );

  // spread of the scanned window, always non-negative so it fits unsigned
  assign spread = SPREAD_W'(mm_hi - mm_lo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
    end else if (seq_clear) begin
      best_r <= '0;
    end else if (best_upd && (spread > best_r)) begin
      best_r <= spread;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= best_r;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.max_spread = out_data_r;

endmodule

>>> sv/swms_checker.sv
module swms_checker
  import swms_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_last,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SPREAD_W-1:0] out_max_spread
);

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid in the cycle after reset");

  // the closing item of a sequence stalls the input in the cycle after it is taken
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input ready right after a closing item");

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn while stalled");

  // and keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_max_spread))
    else $error("result changed while stalled");

endmodule

bind sliding_window_max_spread swms_checker u_swms_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .in_last        (in_if.last),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_max_spread (out_if.max_spread)
);

>>> dv/sliding_window_max_spread_test.sv
`timescale 1ns / 100ps

module sliding_window_max_spread_test;
  import swms_pkg::*;

  localparam int unsigned WINDOW_MAX    = 64;
  localparam int unsigned SETTLE_CYCLES = WINDOW_MAX + 8;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned RANDOM_ITEMS  = 1450;
  localparam int unsigned CYCLE_LIMIT   = 1_200_000;
  localparam logic [PADDR_W-1:0] WSZ_ADDR = PADDR_W'(REG_WINDOW_SIZE) << 2;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  // value is the window size on a config row, the sample on an item row
  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] value;
    logic        is_last;
    logic        typed;
    logic [31:0] spread;
  } stim_row_t;

  localparam int unsigned DIRECTED_ROWS = 28;
  localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    // window of one after reset: spread always zero
    '{ROW_ITEM, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{ROW_ITEM, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
    // full 32-bit spread, both orders
    '{ROW_CFG,  32'd2,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{ROW_ITEM, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h8000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
    // sequence shorter than the window
    '{ROW_ITEM, 32'd5,         1'b1, 1'b1, 32'h0},
    // size zero behaves as one
    '{ROW_CFG,  32'd0,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h0000_0000, 1'b1, 1'b1, 32'h0},
    // oversize saturates to the maximum: short sequence gives zero
    '{ROW_CFG,  32'd127,       1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'd3,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'hFFFF_FFF7, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'd12,        1'b1, 1'b1, 32'h0},
    // ordinary window of three
    '{ROW_CFG,  32'd3,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'd1,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'd4,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'd2,         1'b1, 1'b0, 32'h0},
    // size changed part way through a sequence
    '{ROW_CFG,  32'd2,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'd0,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'd100,       1'b0, 1'b0, 32'h0},
    '{ROW_CFG,  32'd4,         1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'd50,        1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'hFFFF_FFCE, 1'b1, 1'b0, 32'h0},
    // just over the maximum
    '{ROW_CFG,  32'd65,        1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'd1,         1'b1, 1'b1, 32'h0}
  };

  logic clk;
  logic rst_n;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  swms_in_if  in_if ();
  swms_out_if out_if ();

  sliding_window_max_spread #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predictor state: sample chain (entry 0 newest), count, running best
  logic [SAMPLE_W-1:0] sample_chain [WINDOW_MAX];
  int unsigned         samples_in_seq;
  logic [SPREAD_W-1:0] best_so_far;
  logic [WSZ_W-1:0]    window_size_reg;

  logic [SPREAD_W-1:0] expected_spreads [$];
  int unsigned mismatches;
  int unsigned items_sent;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
  endtask

  function automatic int unsigned eff_window();
    if (window_size_reg == 0) return 1;
    if (window_size_reg > WINDOW_MAX) return WINDOW_MAX;
    return window_size_reg;
  endfunction

  // shift the sample in, fold the closed window's spread, emit on last
  function automatic bit fold_sample(input logic [SAMPLE_W-1:0] smp, input logic is_last,
                                     output logic [SPREAD_W-1:0] spread_out);
    int unsigned k;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic signed [SAMPLE_W-1:0] v;
    logic [SAMPLE_W:0] diff;
    k = eff_window();
    for (int i = WINDOW_MAX - 1; i > 0; i--) sample_chain[i] = sample_chain[i-1];
    sample_chain[0] = smp;
    if (samples_in_seq < WINDOW_MAX) samples_in_seq++;
    if (samples_in_seq >= k) begin
      lo = sample_chain[0];
      hi = lo;
      for (int i = 1; i < k; i++) begin
        v = sample_chain[i];
        if (v < lo) lo = v;
        if (v > hi) hi = v;
      end
      diff = {hi[SAMPLE_W-1], hi} - {lo[SAMPLE_W-1], lo};
      if (diff[SPREAD_W-1:0] > best_so_far) best_so_far = diff[SPREAD_W-1:0];
    end
    spread_out = best_so_far;
    if (!is_last) return 1'b0;
    best_so_far    = '0;
    samples_in_seq = 0;
    return 1'b1;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      4, 5:    return SAMPLE_W'(int'($urandom_range(0, 200)) - 100);
      6:       return 32'h8000_0000;
      7:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WSZ_W-1:0] rand_window();
    case ($urandom_range(0, 3))
      0, 1:    return WSZ_W'($urandom_range(1, 8));
      2:       return WSZ_W'($urandom_range(9, WINDOW_MAX));
      default: return WSZ_W'($urandom_range(0, 127));
    endcase
  endfunction

  // lengths around the window so that most sequences close windows
  function automatic int unsigned pick_len(input int unsigned k);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 1;
    if (r < 3) return $urandom_range(1, k);
    if (r < 9) return $urandom_range(k, k + 12);
    return $urandom_range(k, 2 * k + 8);
  endfunction

  // offer one item, predict on acceptance, then idle for gap cycles
  task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic is_last,
                           input logic typed, input logic [SPREAD_W-1:0] typed_spread,
                           input int unsigned gap);
    logic [SPREAD_W-1:0] predicted;
    bit has_result;
    in_if.valid  <= 1'b1;
    in_if.sample <= smp;
    in_if.last   <= is_last;
    do @(posedge clk); while (!in_if.ready);
    has_result = fold_sample(smp, is_last, predicted);
    if (has_result) expected_spreads = {expected_spreads, typed ? typed_spread : predicted};
    items_sent++;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain results, then give an item with no result time to finish
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_spreads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write window_size with junk in the upper bits, then read it back
  task automatic write_window_size(input logic [WSZ_W-1:0] wsz);
    logic [PDATA_W-1:0] word;
    word = $urandom;
    word[WSZ_W-1:0] = wsz;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= WSZ_ADDR;
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    window_size_reg = wsz;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== PDATA_W'(wsz)) report_mismatch("window_size readback",
                                                      PDATA_W'(wsz), cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // result side: check every result taken, random ready with runs and stalls
  initial begin
    int unsigned run_left;
    int unsigned stall_left;
    int unsigned hold_left;
    logic [SPREAD_W-1:0] want;
    logic rdy;
    run_left   = 0;
    stall_left = 0;
    hold_left  = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (expected_spreads.size() == 0) begin
          report_mismatch("unexpected max_spread", '0, out_if.max_spread);
        end else begin
          want = expected_spreads.pop_front();
          if (out_if.max_spread !== want) report_mismatch("max_spread", want, out_if.max_spread);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        rdy       = 1'b0;
      end else begin
        if (run_left == 0 && stall_left == 0) begin
          run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                   : $urandom_range(1, 8);
          stall_left = pick_gap();
        end
        if (run_left != 0) begin
          run_left--;
          rdy = 1'b1;
        end else begin
          stall_left--;
          rdy = 1'b0;
        end
      end
      out_if.ready <= rdy;
    end
  end

  // watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned phase;
    int unsigned k;
    int unsigned len;
    bit steady;
    logic [WSZ_W-1:0] wsz;
    mismatches     = 0;
    items_sent     = 0;
    hold_req       = 1'b0;
    samples_in_seq = 0;
    best_so_far    = '0;
    window_size_reg = WSZ_RESET;
    foreach (sample_chain[i]) sample_chain[i] = '0;
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    in_if.last   <= 1'b0;
    cfg_psel     <= 1'b0;
    cfg_penable  <= 1'b0;
    cfg_pwrite   <= 1'b0;
    cfg_paddr    <= '0;
    cfg_pwdata   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        wait_idle();
        write_window_size(DIRECTED[r].value[WSZ_W-1:0]);
      end else begin
        send_item(DIRECTED[r].value, DIRECTED[r].is_last, DIRECTED[r].typed,
                  DIRECTED[r].spread, pick_gap());
      end
    end

    // random phases, each under its own window size
    items_sent = 0;
    phase      = 0;
    while (items_sent < RANDOM_ITEMS) begin
      wait_idle();
      case (phase)
        0:       wsz = WSZ_W'(WINDOW_MAX);
        1:       wsz = 7'd1;
        2:       wsz = 7'd0;
        3:       wsz = 7'd127;
        4:       wsz = 7'd65;
        5:       wsz = 7'd2;
        default: wsz = rand_window();
      endcase
      write_window_size(wsz);
      k = eff_window();

      // receiver holds off while short sequences pour in back to back
      if (phase == 3) begin
        hold_req = 1'b1;
        repeat (40) send_item(rand_sample(), $urandom_range(0, 2) != 0, 1'b0, '0, 0);
      end

      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 6)) begin
        len = pick_len(k);
        for (int n = 1; n <= len && items_sent < RANDOM_ITEMS; n++)
          send_item(rand_sample(), n == len, 1'b0, '0, steady ? 0 : pick_gap());
      end
      // sometimes leave a sequence open across the size change
      if ($urandom_range(0, 2) == 0 && items_sent < RANDOM_ITEMS) begin
        repeat ($urandom_range(1, k)) send_item(rand_sample(), 1'b0, 1'b0, '0, pick_gap());
      end
      phase++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
